// File: design/aer_pkg.sv
// Package for the alert event recorder: request, response and configuration types,
// operation codes, register indexes and default sizes.
// No dependencies; every other design file imports it.
package aer_pkg;

   localparam int NUM_ALERTS_DEF  = 8;
   localparam int FW_FAULT_ID_DEF = 1;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   localparam logic [1:0] OP_RAISE    = 2'd0;
   localparam logic [1:0] OP_FINALIZE = 2'd1;
   localparam logic [1:0] OP_CLEAR    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PERSISTENT_FATAL = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FATAL_ALERT_MASK = 4'd1;

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  alarm_id;
      logic [7:0]  alert_code;
      logic [31:0] timestamp;
   } req_type;

   typedef struct packed {
      logic        has_record;
      logic [31:0] rec_time;
      logic [3:0]  rec_id;
      logic [7:0]  rec_code;
      logic        rec_started;
      logic [7:0]  active_mask;
      logic        fatal_flag;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic       persistent_fatal;
      logic [7:0] fatal_alert_mask;
   } cfg_type;

endpackage

// File: design/aer_cfg.sv
// Configuration registers of the alert event recorder.
// Depends on aer_pkg for the register indexes and the configuration struct.
module aer_cfg (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [aer_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [aer_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output aer_pkg::cfg_type                  cfg
);
   import aer_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PERSISTENT_FATAL: cfg_in.persistent_fatal = csr_wdata[0];
            CSR_FATAL_ALERT_MASK: cfg_in.fatal_alert_mask = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.persistent_fatal <= 1'b1;
         cfg_ff.fatal_alert_mask <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/aer_seq.sv
// Alert state, request sequencer and result register of the alert event recorder.
// A finalize request walks the ended alerts one id per cycle while not stalled.
// Depends on aer_pkg for the request, response and configuration types.
module aer_seq #(
   parameter int NumAlerts = aer_pkg::NUM_ALERTS_DEF,
   parameter int FwFaultId = aer_pkg::FW_FAULT_ID_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  aer_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  aer_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output aer_pkg::rsp_type  rsp_data
);
   import aer_pkg::*;

   localparam int MaskW = (NumAlerts > 8) ? NumAlerts : 8;
   localparam int IdxW  = (NumAlerts > 1) ? $clog2(NumAlerts) : 1;
   localparam logic [NumAlerts-1:0] FwBit = NumAlerts'(1) << (FwFaultId - 1);

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   state_type             state_ff, state_in;
   logic [NumAlerts-1:0]  active_ff, active_in;
   logic [NumAlerts-1:0]  pending_ff, pending_in;
   logic [NumAlerts-1:0]  ended_ff, ended_in;
   logic [7:0]            fault_ff, fault_in;
   logic                  fatal_ff, fatal_in;
   logic [IdxW-1:0]       idx_ff, idx_in;
   logic [31:0]           time_ff, time_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  out_free;
   logic                  id_ok;
   logic                  already;
   logic [NumAlerts-1:0]  id_mask;
   logic [NumAlerts-1:0]  fatal_mask;
   logic [NumAlerts-1:0]  ended;
   logic [NumAlerts-1:0]  rest;
   logic [MaskW-1:0]      fatal_ext;
   logic [MaskW-1:0]      active_ext;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign fatal_ext  = MaskW'(cfg.fatal_alert_mask);
   assign fatal_mask = fatal_ext[NumAlerts-1:0];
   assign id_ok      = (req_data.alarm_id != 4'd0) &&
                       ({28'd0, req_data.alarm_id} <= 32'(NumAlerts));
   assign id_mask    = NumAlerts'(1) << (req_data.alarm_id - 4'd1);
   assign ended      = active_ff & ~pending_ff;
   assign rest       = ended_ff & ~(NumAlerts'(1) << idx_ff);

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      pending_in   = pending_ff;
      ended_in     = ended_ff;
      fault_in     = fault_ff;
      fatal_in     = fatal_ff;
      idx_in       = idx_ff;
      time_in      = time_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      already      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in.last = 1'b1;
               case (req_data.op)
                  OP_RAISE: begin
                     if (id_ok) begin
                        already = |(active_ff & id_mask);
                        if (id_mask == FwBit) begin
                           already  = already && (req_data.alert_code == fault_ff);
                           fault_in = req_data.alert_code;
                        end
                        if (!already) begin
                           rsp_data_in.has_record  = 1'b1;
                           rsp_data_in.rec_time    = req_data.timestamp;
                           rsp_data_in.rec_id      = req_data.alarm_id;
                           rsp_data_in.rec_code    = req_data.alert_code;
                           rsp_data_in.rec_started = 1'b1;
                        end
                        if (|(fatal_mask & id_mask)) begin
                           fatal_in = 1'b1;
                        end
                        pending_in = pending_ff | id_mask;
                     end
                  end
                  OP_FINALIZE: begin
                     active_in  = pending_ff;
                     pending_in = '0;
                     if (!cfg.persistent_fatal && !(|(active_ff & fatal_mask))) begin
                        fatal_in = 1'b0;
                     end
                     if (|(ended & FwBit)) begin
                        fault_in = 8'd0;
                     end
                     if (ended != '0) begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                        ended_in     = ended;
                        idx_in       = '0;
                        time_in      = req_data.timestamp;
                     end
                  end
                  OP_CLEAR: begin
                     fatal_in = 1'b0;
                  end
                  default: begin
                     fatal_in = fatal_ff;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               if (ended_ff[idx_ff]) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in             = '0;
                  rsp_data_in.has_record  = 1'b1;
                  rsp_data_in.rec_time    = time_ff;
                  rsp_data_in.rec_id      = 4'(32'(idx_ff) + 32'd1);
                  rsp_data_in.rec_started = 1'b0;
                  rsp_data_in.last        = (rest == '0);
                  ended_in                = rest;
                  if (rest == '0) begin
                     state_in = ST_IDLE;
                  end
               end
               idx_in = idx_ff + IdxW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      active_ext              = MaskW'(active_in);
      rsp_data_in.active_mask = active_ext[7:0];
      rsp_data_in.fatal_flag  = fatal_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         pending_ff   <= '0;
         fault_ff     <= '0;
         fatal_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         pending_ff   <= pending_in;
         fault_ff     <= fault_in;
         fatal_ff     <= fatal_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ended_ff    <= ended_in;
      idx_ff      <= idx_in;
      time_ff     <= time_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: design/alert_event_recorder_core.sv
// Top level of the alert event recorder: configuration registers and sequencer.
// Depends on aer_pkg, aer_cfg and aer_seq.
//
// Requests arrive on req_valid/req_stall/req_data and results leave on
// rsp_valid/rsp_stall/rsp_data. A transfer happens when valid is high and
// stall is low. Every request gives one or more results; the final one has last set.
// A raise or clear request, and a finalize request with no ended alerts, gives
// one registered result, which appears in the cycle after acceptance.
// A finalize request walks alert ids upward from 1, one id per cycle while the
// result register is free, and gives one ended record per alert that was active
// and was not raised again; the walk stops after the last such alert. No new
// request is taken before the walk ends, and a stalled result holds the walk.
// The result register holds a result while rsp_stall is high. A new request is
// taken as soon as the last result of the previous one is taken or is being taken.
// The csr_ write port is always ready; index 0 is persistent_fatal and index 1
// is fatal_alert_mask. Write it only while the block is idle.
// Reset clears all alert state and sets both registers to 1.
module alert_event_recorder_core #(
   parameter int NumAlerts = aer_pkg::NUM_ALERTS_DEF,
   parameter int FwFaultId = aer_pkg::FW_FAULT_ID_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  aer_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output aer_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [aer_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [aer_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import aer_pkg::*;

   cfg_type cfg;

   aer_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   aer_seq #(
      .NumAlerts (NumAlerts),
      .FwFaultId (FwFaultId)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: design/aer_chk.sv
// Port checker for the alert event recorder, bound to the top level.
// Depends on aer_pkg and alert_event_recorder_core.
module aer_chk (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  aer_pkg::req_type  req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  aer_pkg::rsp_type  rsp_data
);
   import aer_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled response changed.");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> req_stall)
      else $error("Request taken while results of the previous request remain.");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_record |-> rsp_data.last)
      else $error("Response without a record is not the last one.");

   a_ended_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.has_record && !rsp_data.rec_started |-> rsp_data.rec_code == 8'd0)
      else $error("Ended record carries a nonzero code.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid right after reset.");

endmodule

bind alert_event_recorder_core aer_chk u_chk (.*);
